// ===== hdl/vertex_matrix_transform_macros.svh =====
// ---------------------------------------------------------------------------
// Vertex matrix transform assertion macros
// Shared concurrent assertion forms for the vertex transform RTL.
// ---------------------------------------------------------------------------
`ifndef VERTEX_MATRIX_TRANSFORM_MACROS_SVH
`define VERTEX_MATRIX_TRANSFORM_MACROS_SVH

// Checked on every rising edge of clk_i while rst_ni is high.
`define VMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define VMT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/vmt_pkg.sv =====
// ---------------------------------------------------------------------------
// Vertex matrix transform package
// Payload types, pipeline control type and register constants.
// ---------------------------------------------------------------------------
package vmt_pkg;

  localparam int unsigned FIELD_W          = 32;
  localparam int unsigned CFG_DATA_W       = 64;
  localparam int unsigned CFG_INDEX_W      = 8;
  localparam int unsigned NUM_REGS         = 8;
  localparam int unsigned NUM_LANES        = 4;
  localparam int unsigned DEF_COORD_WIDTH  = 32;
  localparam int unsigned DEF_FRAC_BITS    = 16;

  // Identity matrix after reset, two coefficients per register.
  localparam logic [CFG_DATA_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  typedef struct packed {
    logic signed [FIELD_W-1:0] in_x;
    logic signed [FIELD_W-1:0] in_y;
    logic signed [FIELD_W-1:0] in_z;
    logic signed [FIELD_W-1:0] in_w;
  } vertex_in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic signed [FIELD_W-1:0] out_w;
  } vertex_out_t;

  // Load enables for the four pipeline stages of a dot-product lane.
  typedef struct packed {
    logic load_mul;
    logic load_pair;
    logic load_sum;
    logic load_out;
  } vmt_stage_ctrl_t;

endpackage

// ===== hdl/vertex_matrix_transform.sv =====
// ---------------------------------------------------------------------------
// Vertex matrix transform
// Homogeneous row vector (x, y, z, w) times a configurable 4x4 matrix.
// ---------------------------------------------------------------------------
// The block takes one vertex per transfer and returns the row vector times
// the matrix held in the eight configuration registers, in signed fixed point
// with FRAC_BITS fraction bits. Each output column is the exact sum of four
// full-precision products, shifted right with rounding toward minus infinity
// and saturated to COORD_WIDTH bits. A vertex passes the multiply stage with
// its sixteen parallel multipliers, the pairwise and final add stages of the
// adder tree and the shift and saturate stage that is also the output register.
// One vertex can be accepted every cycle unless an output stall has filled all
// stages of the four-deep pipeline, whose stages fill any bubble when the output
// side stalls. After reset the matrix is the identity. The user must write
// registers only while no vertex is in flight; the block does not enforce it.
// Writes to an index of eight or above are ignored.
module vertex_matrix_transform #(
  parameter int unsigned COORD_WIDTH = vmt_pkg::DEF_COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = vmt_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Vertex input channel.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  vmt_pkg::vertex_in_t                in_data_i,
  // Transformed vertex output channel.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output vmt_pkg::vertex_out_t               out_data_o,
  // Matrix register write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [vmt_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [vmt_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned REG_IDX_W = $clog2(vmt_pkg::NUM_REGS);
  localparam int unsigned HALF_W    = vmt_pkg::CFG_DATA_W / 2;

  // Matrix registers. Register 2*row + col/2 holds the even column in its
  // low half and the odd column in its high half.
  logic [vmt_pkg::CFG_DATA_W-1:0] mat_q [vmt_pkg::NUM_REGS];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < int'(vmt_pkg::NUM_REGS); r++) begin
        mat_q[r] <= vmt_pkg::CFG_RESET[r];
      end
    end else if (cfg_valid_i && (cfg_index_i < vmt_pkg::CFG_INDEX_W'(vmt_pkg::NUM_REGS))) begin
      mat_q[cfg_index_i[REG_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // Pipeline control. Each stage carries a valid bit; a stage may load when
  // it is empty or when its content moves on in the same cycle, so a stall
  // at the output only backs up as far as the first empty stage.
  logic mul_q, pair_q, sum_q, out_q;
  logic rdy_mul, rdy_pair, rdy_sum, rdy_out;
  vmt_pkg::vmt_stage_ctrl_t ctrl;

  assign rdy_out  = !out_q  || out_ready_i;
  assign rdy_sum  = !sum_q  || rdy_out;
  assign rdy_pair = !pair_q || rdy_sum;
  assign rdy_mul  = !mul_q  || rdy_pair;

  assign in_ready_o  = rdy_mul;
  assign out_valid_o = out_q;

  assign ctrl.load_mul  = in_valid_i && rdy_mul;
  assign ctrl.load_pair = mul_q  && rdy_pair;
  assign ctrl.load_sum  = pair_q && rdy_sum;
  assign ctrl.load_out  = sum_q  && rdy_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      pair_q <= 1'b0;
      sum_q  <= 1'b0;
      out_q  <= 1'b0;
    end else begin
      if (rdy_mul)  mul_q  <= in_valid_i;
      if (rdy_pair) pair_q <= mul_q;
      if (rdy_sum)  sum_q  <= pair_q;
      if (rdy_out)  out_q  <= sum_q;
    end
  end

  // Coordinates, narrowed to COORD_WIDTH bits; each lane sign-extends them.
  logic [vmt_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0] coord;

  assign coord[0] = in_data_i.in_x[COORD_WIDTH-1:0];
  assign coord[1] = in_data_i.in_y[COORD_WIDTH-1:0];
  assign coord[2] = in_data_i.in_z[COORD_WIDTH-1:0];
  assign coord[3] = in_data_i.in_w[COORD_WIDTH-1:0];

  logic signed [vmt_pkg::FIELD_W-1:0] col_res [vmt_pkg::NUM_LANES];

  // One dot-product lane per output column j, fed with column j of the
  // matrix: coefficient m[i][j] sits in register 2*i + j/2, half j%2.
  for (genvar j = 0; j < vmt_pkg::NUM_LANES; j++) begin : g_col
    logic [vmt_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0] coef;

    for (genvar i = 0; i < vmt_pkg::NUM_LANES; i++) begin : g_row
      assign coef[i] = mat_q[2 * i + j / 2][(j % 2) * HALF_W +: COORD_WIDTH];
    end

    vmt_dot #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_dot (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .coord_i  (coord),
      .coef_i   (coef),
      .result_o (col_res[j])
    );
  end

  assign out_data_o.out_x = col_res[0];
  assign out_data_o.out_y = col_res[1];
  assign out_data_o.out_z = col_res[2];
  assign out_data_o.out_w = col_res[3];

  // Assertions.
  `include "vertex_matrix_transform_macros.svh"

  logic [3:0] occ;
  assign occ = {mul_q, pair_q, sum_q, out_q};

  // The input side can only be blocked when every stage holds a vertex.
  `VMT_ASSERT(a_full_when_blocked, !in_ready_o |-> (occ == 4'b1111), "input blocked with a bubble in the pipeline")

  // A vertex that enters without one leaving raises the occupancy by one.
  `VMT_ASSERT(a_count_up, (in_valid_i && in_ready_o && !(out_valid_o && out_ready_i)) |=> ($countones(occ) == $countones($past(occ)) + 1), "vertex lost or duplicated on entry")

  // With the output taking results, a vertex in the final add stage shows up.
  `VMT_ASSERT(a_drain, (sum_q && out_ready_i) |=> out_valid_o, "pipeline failed to advance into the output stage")

  // The write channel never pushes back.
  `VMT_ASSERT_ALWAYS(a_cfg_ready, cfg_ready_o, "configuration channel stalled")

endmodule

// ===== hdl/vmt_dot.sv =====
// ---------------------------------------------------------------------------
// Vertex matrix transform dot-product lane
// Four-stage pipeline: multiply, pairwise add, final add, shift and saturate.
// ---------------------------------------------------------------------------
module vmt_dot #(
  parameter int unsigned COORD_WIDTH = vmt_pkg::DEF_COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = vmt_pkg::DEF_FRAC_BITS
) (
  input  logic                                               clk_i,
  input  vmt_pkg::vmt_stage_ctrl_t                           ctrl_i,
  input  logic [vmt_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0]     coord_i,
  input  logic [vmt_pkg::NUM_LANES-1:0][COORD_WIDTH-1:0]     coef_i,
  output logic signed [vmt_pkg::FIELD_W-1:0]                 result_o
);

  localparam int unsigned PROD_W = 2 * COORD_WIDTH;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;

  logic signed [PROD_W-1:0] prod_q [vmt_pkg::NUM_LANES];
  logic signed [PAIR_W-1:0] pair_lo_q, pair_hi_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic signed [SUM_W-1:0]  shifted;
  logic signed [COORD_WIDTH-1:0] sat;
  logic signed [vmt_pkg::FIELD_W-1:0] result_q;

  for (genvar i = 0; i < vmt_pkg::NUM_LANES; i++) begin : g_mul
    always_ff @(posedge clk_i) begin
      if (ctrl_i.load_mul) begin
        prod_q[i] <= $signed(coord_i[i]) * $signed(coef_i[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_pair) begin
      pair_lo_q <= PAIR_W'(prod_q[0]) + PAIR_W'(prod_q[1]);
      pair_hi_q <= PAIR_W'(prod_q[2]) + PAIR_W'(prod_q[3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_sum) begin
      sum_q <= SUM_W'(pair_lo_q) + SUM_W'(pair_hi_q);
    end
  end

  // Floor division by the fraction scale, then clamp when the bits above the
  // result's sign bit do not all agree with it.
  always_comb begin
    shifted = sum_q >>> FRAC_BITS;
    if (&shifted[SUM_W-1:COORD_WIDTH-1] || ~|shifted[SUM_W-1:COORD_WIDTH-1]) begin
      sat = shifted[COORD_WIDTH-1:0];
    end else begin
      sat = {shifted[SUM_W-1], {(COORD_WIDTH-1){~shifted[SUM_W-1]}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      result_q <= vmt_pkg::FIELD_W'(sat);
    end
  end

  assign result_o = result_q;

endmodule

// ===== tb/vertex_matrix_transform_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Vertex matrix transform checker
// Watches the three channels of the vertex transform, keeps its own copy of
// the matrix, predicts each transformed vertex and compares it on transfer.
// ---------------------------------------------------------------------------
module vertex_matrix_transform_checker
  import vmt_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  vertex_in_t             in_data_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  vertex_out_t            out_data_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int unsigned            pending_o,
  output int unsigned            fail_count_o
);

  logic [CFG_DATA_W-1:0] matrix_regs [NUM_REGS];
  vertex_out_t           expected_q [$];
  int unsigned           fail_total;

  // Keeps the low COORD_WIDTH bits and sign-extends them to a full field.
  function automatic logic signed [FIELD_W-1:0] narrow(input logic [FIELD_W-1:0] w);
    return $signed(w << (FIELD_W - COORD_WIDTH)) >>> (FIELD_W - COORD_WIDTH);
  endfunction

  // The exact sum of four products fits in 66 bits, so a 68-bit accumulator
  // gives one floor shift of the whole sum, then saturation.
  function automatic vertex_out_t transform_vertex(input vertex_in_t v);
    logic signed [FIELD_W-1:0] coord [NUM_LANES];
    logic signed [FIELD_W-1:0] lane [NUM_LANES];
    logic signed [FIELD_W-1:0] coeff;
    logic [CFG_DATA_W-1:0]     reg_word;
    logic signed [67:0]        acc;
    logic signed [67:0]        hi_lim;
    logic signed [67:0]        lo_lim;
    vertex_out_t               r;
    coord[0] = narrow(v.in_x);
    coord[1] = narrow(v.in_y);
    coord[2] = narrow(v.in_z);
    coord[3] = narrow(v.in_w);
    hi_lim = (68'sd1 <<< (COORD_WIDTH - 1)) - 68'sd1;
    lo_lim = -hi_lim - 68'sd1;
    for (int j = 0; j < NUM_LANES; j++) begin
      acc = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        reg_word = matrix_regs[i * 2 + j / 2];
        coeff = narrow((j % 2) ? reg_word[63:32] : reg_word[31:0]);
        acc = acc + coord[i] * coeff;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > hi_lim) acc = hi_lim;
      if (acc < lo_lim) acc = lo_lim;
      lane[j] = acc[FIELD_W-1:0];
    end
    r.out_x = lane[0];
    r.out_y = lane[1];
    r.out_z = lane[2];
    r.out_w = lane[3];
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [FIELD_W-1:0] want,
                             input logic signed [FIELD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
             name, want, want, got, got);
      fail_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_out_t want;
    if (!rst_ni) begin
      matrix_regs = CFG_RESET;
      expected_q.delete();
      fail_total = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      // Results are matched before new vertices are queued, so a result can
      // never be explained by a vertex accepted at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("transformed vertex with none outstanding: x=%0d y=%0d z=%0d w=%0d",
                 out_data_i.out_x, out_data_i.out_y, out_data_i.out_z, out_data_i.out_w);
          fail_total++;
        end else begin
          want = expected_q.pop_front();
          check_field("out_x", want.out_x, out_data_i.out_x);
          check_field("out_y", want.out_y, out_data_i.out_y);
          check_field("out_z", want.out_z, out_data_i.out_z);
          check_field("out_w", want.out_w, out_data_i.out_w);
        end
      end
      if (in_valid_i && in_ready_i) expected_q = {expected_q, transform_vertex(in_data_i)};
      // Writes to an index past the last register are dropped by the block.
      if (cfg_valid_i && cfg_ready_i && cfg_index_i < NUM_REGS) begin
        matrix_regs[cfg_index_i[2:0]] = cfg_data_i;
      end
      pending_o <= expected_q.size();
      fail_count_o <= fail_total;
    end
  end

endmodule

// ===== tb/vertex_matrix_transform_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Vertex matrix transform testbench
// Drives vertices and matrix settings into the transform, with random gaps
// on the input and random stalls on the output, and lets the checker judge
// every transformed vertex.
// ---------------------------------------------------------------------------
module vertex_matrix_transform_test;
  import vmt_pkg::*;

  localparam int unsigned COORD_WIDTH   = DEF_COORD_WIDTH;
  localparam int unsigned FRAC_BITS     = DEF_FRAC_BITS;
  localparam int unsigned NUM_PHASES    = 10;
  localparam int unsigned PHASE_VERTS   = 95;
  // The limit sits far above the slowest legal run, which leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam logic [FIELD_W-1:0] Q_ONE  = 32'h0001_0000;
  localparam logic [FIELD_W-1:0] Q_MAX  = 32'h7FFF_FFFF;
  localparam logic [FIELD_W-1:0] Q_MIN  = 32'h8000_0000;
  localparam logic [FIELD_W-1:0] Q_LSB  = 32'h0000_0001;
  localparam logic [FIELD_W-1:0] Q_NEG1 = 32'hFFFF_FFFF;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  vertex_in_t             in_data_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  vertex_out_t            out_data_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  int unsigned           pending_count;
  int unsigned           fail_count;
  int unsigned           cycle_count = 0;
  int unsigned           vertices_sent = 0;
  int unsigned           reg_writes = 0;
  int unsigned           settings_loaded = 0;
  bit                    calm = 1'b0;
  logic [CFG_DATA_W-1:0] matrix_words [NUM_REGS];

  vertex_matrix_transform #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  vertex_matrix_transform_checker #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending_count),
    .fail_count_o (fail_count)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // A gap or stall on about nine draws in a hundred, except while the run
  // is in its calm stretch, where both sides run at full rate.
  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < 9);
  endfunction

  // The output side stalls on its own schedule, independent of the input.
  always @(posedge clk_i) begin
    out_ready_i <= !take_gap();
  end

  // Signed value within about plus or minus eight, in Q16.16.
  function automatic logic [FIELD_W-1:0] small_word();
    return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
  endfunction

  function automatic logic [FIELD_W-1:0] edge_word();
    case ($urandom_range(6))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return Q_NEG1;
      3:       return Q_ONE;
      4:       return -Q_ONE;
      5:       return Q_LSB;
      default: return '0;
    endcase
  endfunction

  function automatic logic [FIELD_W-1:0] rand_word();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6, 7: return small_word();
      default:    return edge_word();
    endcase
  endfunction

  function automatic vertex_in_t vertex_of(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                                           input logic [FIELD_W-1:0] z, input logic [FIELD_W-1:0] w);
    vertex_in_t v;
    v.in_x = x;
    v.in_y = y;
    v.in_z = z;
    v.in_w = w;
    return v;
  endfunction

  // Offers one vertex and returns at the edge where it was transferred.
  // Valid stays high afterwards so that back-to-back vertices need no
  // second assignment to it in the same step.
  task automatic send_vertex(input vertex_in_t v);
    while (take_gap()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= v;
    do @(posedge clk_i); while (!in_ready_o);
    vertices_sent++;
  endtask

  // Closes a burst and waits until every transformed vertex has come back.
  // The first edge lets the count of outstanding vertices take in the last
  // transfer before it is trusted.
  task automatic finish_burst();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    reg_writes++;
  endtask

  // Loads the whole matrix from matrix_words, optionally followed by a write
  // to an index past the last register, which must leave the matrix alone.
  task automatic program_matrix(input bit stray);
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_INDEX_W'(i), matrix_words[i]);
    if (stray) write_reg(CFG_INDEX_W'($urandom_range(NUM_REGS, 255)), {$urandom(), $urandom()});
    cfg_valid_i <= 1'b0;
    settings_loaded++;
  endtask

  initial begin
    int unsigned kind;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    rst_ni      = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix straight out of reset: zero, both extremes of the range,
    // the smallest negative step, whole numbers and alternating bit patterns.
    send_vertex(vertex_of('0, '0, '0, '0));
    send_vertex(vertex_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_vertex(vertex_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_vertex(vertex_of(Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1));
    send_vertex(vertex_of(Q_ONE, 2 * Q_ONE, -3 * Q_ONE, Q_ONE));
    send_vertex(vertex_of(32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 32'hCCCC_CCCC));
    finish_burst();

    // Writes past the last register index must be dropped, so the next vertex
    // still sees the identity.
    write_reg(CFG_INDEX_W'(NUM_REGS), 64'hDEAD_BEEF_1234_5678);
    write_reg('1, '1);
    cfg_valid_i <= 1'b0;
    send_vertex(vertex_of(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, Q_ONE));
    finish_burst();

    // Every coefficient at the largest value: positive and negative overflow,
    // and tiny inputs whose products round toward minus infinity.
    foreach (matrix_words[i]) matrix_words[i] = {Q_MAX, Q_MAX};
    program_matrix(1'b0);
    send_vertex(vertex_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_vertex(vertex_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_vertex(vertex_of(Q_LSB, Q_LSB, Q_LSB, Q_LSB));
    send_vertex(vertex_of(Q_NEG1, Q_NEG1, Q_NEG1, Q_NEG1));
    finish_burst();

    // Every coefficient at the smallest value: the product of two minimums
    // is the largest magnitude a product can reach.
    foreach (matrix_words[i]) matrix_words[i] = {Q_MIN, Q_MIN};
    program_matrix(1'b0);
    send_vertex(vertex_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    send_vertex(vertex_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    send_vertex(vertex_of(Q_NEG1, '0, '0, '0));
    send_vertex(vertex_of(Q_LSB, '0, '0, '0));
    finish_burst();

    // All coefficients at minus one LSB, then an all-zero matrix.
    foreach (matrix_words[i]) matrix_words[i] = '1;
    program_matrix(1'b0);
    send_vertex(vertex_of(Q_LSB, '0, '0, '0));
    send_vertex(vertex_of(Q_ONE, Q_MIN, Q_MAX, Q_NEG1));
    finish_burst();
    foreach (matrix_words[i]) matrix_words[i] = '0;
    program_matrix(1'b0);
    send_vertex(vertex_of(Q_MAX, Q_MIN, Q_NEG1, Q_ONE));
    finish_burst();

    // Random phases, each with a fresh matrix of one of several flavors.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      kind = ph % 5;
      calm = (ph == 4 || ph == 5);
      case (kind)
        0: begin
          // Rotation and scale within plus or minus two, arbitrary translation.
          foreach (matrix_words[i]) begin
            matrix_words[i] = {$urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                               $urandom_range(0, 32'h0004_0000) - 32'h0002_0000};
          end
          matrix_words[6] = {rand_word(), rand_word()};
          matrix_words[7] = {rand_word(), rand_word()};
        end
        1: begin
          // Pure translation on top of the identity.
          matrix_words = CFG_RESET;
          matrix_words[6] = {rand_word(), rand_word()};
          matrix_words[7][31:0] = rand_word();
        end
        2: foreach (matrix_words[i]) matrix_words[i] = {$urandom(), $urandom()};
        3: foreach (matrix_words[i]) matrix_words[i] = {edge_word(), edge_word()};
        default: foreach (matrix_words[i]) matrix_words[i] = {rand_word(), rand_word()};
      endcase
      program_matrix(ph % 3 == 0);
      for (int n = 0; n < PHASE_VERTS; n++) begin
        // Mostly ordinary points with w of one, the rest anything at all.
        if ($urandom_range(9) < 6) begin
          send_vertex(vertex_of(small_word(), small_word(), small_word(), Q_ONE));
        end else begin
          send_vertex(vertex_of(rand_word(), rand_word(), rand_word(), rand_word()));
        end
      end
      finish_burst();
    end
    calm = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Transformed %0d vertices under %0d matrix settings (%0d register writes),",
             vertices_sent, settings_loaded + 1, reg_writes);
    $display("covering saturation, floor rounding and writes to unused register indexes.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
